// ===== design/ille_pkg.sv =====
// ----------------------------------------------------------------------------
// ille_pkg
// shared types and constants of the indexed linked list engine
// ----------------------------------------------------------------------------
package ille_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int LINK_W    = 7;
	localparam int COUNT_W   = 7;
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 3;

	localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

	typedef enum logic [1:0] {
		OP_APPEND  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_REVERSE = 2'd2,
		OP_DUMP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AP_FREE,
		S_AP_WALK,
		S_DL_WALK,
		S_DL_FREE,
		S_RV_WALK,
		S_DP_READ,
		S_EMIT
	} state_t;

endpackage

// ===== design/indexed_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// singly linked list in a node store with a free list, driven by commands
// ----------------------------------------------------------------------------
// requests arrive on the s_axis channel: tuser carries the command (append,
// delete first match, reverse, dump) and tdata the value. results leave on
// the m_axis channel, one per command except a dump, which gives one result
// per element from head to tail with tlast on the final one. every result
// carries the element count after the command.
// one request is taken at a time; s_axis_tready is high only while the
// sequencer is idle. the walk goes through the link store, which has one
// registered read port, so the walk visits the nodes in turn:
//   append  : takes the free head, then on a non-empty list walks to the tail
//   delete  : walks from the head to the first match and frees that node
//   reverse : walks the whole list, turning each link back
//   dump    : walks from the head, giving a result for each node read
//   full or empty answers need no walk
// results sit in an output register, so a new request is taken while the
// last result still waits; a stalled receiver holds the walk of a dump and
// the final answer of any other command. reset clears the list at once:
// link entries never written read as their reset chain, so no clearing pass.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine #(
	parameter int CAPACITY   = ille_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ille_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [ille_pkg::S_TDATA_W-1:0] s_axis_tdata,  // value
	input  logic [ille_pkg::S_TUSER_W-1:0] s_axis_tuser,  // op
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [ille_pkg::M_TDATA_W-1:0] m_axis_tdata,  // item_value, count, zero pad
	output logic [ille_pkg::M_TUSER_W-1:0] m_axis_tuser,  // status, item_valid
	output logic                           m_axis_tlast
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [ille_pkg::LINK_W-1:0]  CAP_L   = ille_pkg::LINK_W'(CAPACITY);
	localparam logic [ille_pkg::COUNT_W-1:0] CAP_C   = ille_pkg::COUNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0]             LAST_IX = IDX_W'(CAPACITY - 1);

	typedef logic [ille_pkg::LINK_W-1:0] link_t;

	function automatic logic is_node(input link_t x);
		return x < CAP_L;
	endfunction

	// node stores
	logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
	link_t                 lnk_mem [CAPACITY];
	logic [CAPACITY-1:0]   lnk_vld_q;

	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  lw_en;
	logic [IDX_W-1:0]      lw_addr;
	link_t                 lw_data;
	logic                  vw_en;
	logic [IDX_W-1:0]      vw_addr;
	logic [DATA_WIDTH-1:0] vw_data;

	logic [DATA_WIDTH-1:0] val_rd_q;
	link_t                 lnk_rd_q;
	logic                  lnk_rd_vld_q;
	logic [IDX_W-1:0]      rd_addr_q;
	link_t                 link_rd;

	// sequencer and list state
	ille_pkg::state_t      state_q, state_d;
	ille_pkg::status_t     st_q, st_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	link_t                 cur_q, cur_d;
	link_t                 prev_q, prev_d;
	link_t                 head_q, head_d;
	link_t                 free_q, free_d;
	logic [ille_pkg::COUNT_W-1:0] count_q, count_d;

	// output register
	logic                         out_valid_q, out_valid_d;
	ille_pkg::status_t            out_status_q, out_status_d;
	logic [31:0]                  out_value_q, out_value_d;
	logic                         out_ivalid_q, out_ivalid_d;
	logic                         out_last_q, out_last_d;
	logic [ille_pkg::COUNT_W-1:0] out_count_q, out_count_d;
	logic                         out_free;

	logic signed [31:0]           in_val_s;
	logic signed [63:0]           in_ext;
	logic signed [DATA_WIDTH-1:0] rd_val_s;
	logic signed [63:0]           rd_ext;
	logic [ille_pkg::COUNT_W-1:0] count_inc;
	logic [ille_pkg::COUNT_W-1:0] count_dec;

	assign in_val_s  = s_axis_tdata;
	assign in_ext    = 64'(in_val_s);
	assign rd_val_s  = val_rd_q;
	assign rd_ext    = 64'(rd_val_s);
	assign count_inc = (count_q < CAP_C) ? count_q + 1'b1 : count_q;
	assign count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;

	// unwritten link entries read as the reset chain
	always_comb begin
		if (lnk_rd_vld_q) begin
			link_rd = lnk_rd_q;
		end else if (rd_addr_q == LAST_IX) begin
			link_rd = ille_pkg::NULL_LINK;
		end else begin
			link_rd = ille_pkg::LINK_W'(rd_addr_q) + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vw_en) begin
			val_mem[vw_addr] <= vw_data;
		end
		if (lw_en) begin
			lnk_mem[lw_addr] <= lw_data;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[rd_addr];
			lnk_rd_q <= lnk_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lnk_vld_q    <= '0;
			lnk_rd_vld_q <= 1'b0;
			rd_addr_q    <= '0;
		end else begin
			if (lw_en) begin
				lnk_vld_q[lw_addr] <= 1'b1;
			end
			if (rd_en) begin
				lnk_rd_vld_q <= lnk_vld_q[rd_addr];
				rd_addr_q    <= rd_addr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ille_pkg::S_IDLE;
			head_q      <= ille_pkg::NULL_LINK;
			free_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			free_q      <= free_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		st_q         <= st_d;
		val_q        <= val_d;
		cur_q        <= cur_d;
		prev_q       <= prev_d;
		out_status_q <= out_status_d;
		out_value_q  <= out_value_d;
		out_ivalid_q <= out_ivalid_d;
		out_last_q   <= out_last_d;
		out_count_q  <= out_count_d;
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d      = state_q;
		st_d         = st_q;
		val_d        = val_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		head_d       = head_q;
		free_d       = free_q;
		count_d      = count_q;
		out_valid_d  = out_valid_q && !m_axis_tready;
		out_status_d = out_status_q;
		out_value_d  = out_value_q;
		out_ivalid_d = out_ivalid_q;
		out_last_d   = out_last_q;
		out_count_d  = out_count_q;
		rd_en        = 1'b0;
		rd_addr      = cur_q[IDX_W-1:0];
		lw_en        = 1'b0;
		lw_addr      = cur_q[IDX_W-1:0];
		lw_data      = prev_q;
		vw_en        = 1'b0;
		vw_addr      = prev_q[IDX_W-1:0];
		vw_data      = val_q;
		s_axis_tready = (state_q == ille_pkg::S_IDLE);

		case (state_q)
			ille_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					val_d  = in_ext[DATA_WIDTH-1:0];
					cur_d  = head_q;
					prev_d = ille_pkg::NULL_LINK;
					case (ille_pkg::op_t'(s_axis_tuser))
						ille_pkg::OP_APPEND: begin
							if (!is_node(free_q)) begin
								st_d    = ille_pkg::ST_FULL;
								state_d = ille_pkg::S_EMIT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = free_q[IDX_W-1:0];
								prev_d  = free_q;
								state_d = ille_pkg::S_AP_FREE;
							end
						end
						ille_pkg::OP_DELETE: begin
							if (!is_node(head_q)) begin
								st_d    = ille_pkg::ST_EMPTY;
								state_d = ille_pkg::S_EMIT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q[IDX_W-1:0];
								state_d = ille_pkg::S_DL_WALK;
							end
						end
						ille_pkg::OP_REVERSE: begin
							if (!is_node(head_q)) begin
								st_d    = ille_pkg::ST_OK;
								state_d = ille_pkg::S_EMIT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q[IDX_W-1:0];
								state_d = ille_pkg::S_RV_WALK;
							end
						end
						default: begin
							if (!is_node(head_q)) begin
								st_d    = ille_pkg::ST_OK;
								state_d = ille_pkg::S_EMIT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q[IDX_W-1:0];
								state_d = ille_pkg::S_DP_READ;
							end
						end
					endcase
				end
			end
			ille_pkg::S_AP_FREE: begin
				// prev_q holds the node taken from the free list
				free_d  = link_rd;
				vw_en   = 1'b1;
				vw_addr = prev_q[IDX_W-1:0];
				vw_data = val_q;
				lw_en   = 1'b1;
				lw_addr = prev_q[IDX_W-1:0];
				lw_data = ille_pkg::NULL_LINK;
				if (!is_node(head_q)) begin
					head_d  = prev_q;
					count_d = count_inc;
					st_d    = ille_pkg::ST_OK;
					state_d = ille_pkg::S_EMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q[IDX_W-1:0];
					cur_d   = head_q;
					state_d = ille_pkg::S_AP_WALK;
				end
			end
			ille_pkg::S_AP_WALK: begin
				if (is_node(link_rd)) begin
					cur_d   = link_rd;
					rd_en   = 1'b1;
					rd_addr = link_rd[IDX_W-1:0];
				end else begin
					lw_en   = 1'b1;
					lw_addr = cur_q[IDX_W-1:0];
					lw_data = prev_q;
					count_d = count_inc;
					st_d    = ille_pkg::ST_OK;
					state_d = ille_pkg::S_EMIT;
				end
			end
			ille_pkg::S_DL_WALK: begin
				if (val_rd_q == val_q) begin
					if (is_node(prev_q)) begin
						lw_en   = 1'b1;
						lw_addr = prev_q[IDX_W-1:0];
						lw_data = link_rd;
					end else begin
						head_d = link_rd;
					end
					state_d = ille_pkg::S_DL_FREE;
				end else if (is_node(link_rd)) begin
					prev_d  = cur_q;
					cur_d   = link_rd;
					rd_en   = 1'b1;
					rd_addr = link_rd[IDX_W-1:0];
				end else begin
					st_d    = ille_pkg::ST_NOT_FOUND;
					state_d = ille_pkg::S_EMIT;
				end
			end
			ille_pkg::S_DL_FREE: begin
				lw_en   = 1'b1;
				lw_addr = cur_q[IDX_W-1:0];
				lw_data = free_q;
				free_d  = cur_q;
				count_d = count_dec;
				st_d    = ille_pkg::ST_OK;
				state_d = ille_pkg::S_EMIT;
			end
			ille_pkg::S_RV_WALK: begin
				lw_en   = 1'b1;
				lw_addr = cur_q[IDX_W-1:0];
				lw_data = prev_q;
				prev_d  = cur_q;
				if (is_node(link_rd)) begin
					cur_d   = link_rd;
					rd_en   = 1'b1;
					rd_addr = link_rd[IDX_W-1:0];
				end else begin
					head_d  = cur_q;
					st_d    = ille_pkg::ST_OK;
					state_d = ille_pkg::S_EMIT;
				end
			end
			ille_pkg::S_DP_READ: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					out_status_d = ille_pkg::ST_OK;
					out_value_d  = rd_ext[31:0];
					out_ivalid_d = 1'b1;
					out_last_d   = !is_node(link_rd);
					out_count_d  = count_q;
					if (is_node(link_rd)) begin
						rd_en   = 1'b1;
						rd_addr = link_rd[IDX_W-1:0];
					end else begin
						state_d = ille_pkg::S_IDLE;
					end
				end
			end
			ille_pkg::S_EMIT: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					out_status_d = st_q;
					out_value_d  = '0;
					out_ivalid_d = 1'b0;
					out_last_d   = 1'b1;
					out_count_d  = count_q;
					state_d      = ille_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ille_pkg::S_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_value_q};
	assign m_axis_tuser  = {out_ivalid_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== design/ille_checker.sv =====
// ----------------------------------------------------------------------------
// ille_checker
// port-level checks of the indexed linked list engine, bound to the top level
// ----------------------------------------------------------------------------
module ille_checker #(
	parameter int CAPACITY = ille_pkg::CAPACITY_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ille_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [ille_pkg::M_TUSER_W-1:0] m_axis_tuser,
	input logic                           m_axis_tlast
);

	localparam logic [ille_pkg::COUNT_W-1:0] CAP_C = ille_pkg::COUNT_W'(CAPACITY);

	logic [ille_pkg::COUNT_W-1:0] count_w;
	logic [1:0]                   status_w;

	assign count_w  = m_axis_tdata[38:32];
	assign status_w = m_axis_tuser[1:0];

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
			&& $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_w == ille_pkg::ST_FULL |-> count_w == CAP_C)
		else $error("full reported below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_w == ille_pkg::ST_EMPTY |-> count_w == '0)
		else $error("empty reported with elements");

	// results without an element are single and carry zero
	a_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast && m_axis_tdata[31:0] == '0)
		else $error("bad result without element");

endmodule

bind indexed_linked_list_engine ille_checker #(.CAPACITY(CAPACITY)) u_ille_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the indexed linked list engine
// ----------------------------------------------------------------------------
// requests go in on s_axis as command in tuser and value in tdata. a model of
// the node store, its links and the free list is kept here and works out the
// results of every request as it is accepted. results taken from m_axis are
// compared in order with those predictions or with the table's expectations.
// a short table opens the run: empty-list answers, extreme values, a miss,
// reverse and dump, and deletes at head, middle and tail. random requests
// follow in grow and shrink phases, so the store is filled to the point
// of refusing appends and then drained to the point of empty answers. both
// sides idle at random, apart from one calm stretch, and the receiver holds
// off once for a long time to back the block up.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES        = ille_pkg::CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 320;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		ille_pkg::status_t status;
		logic [31:0]       item_value;
		logic              item_valid;
		logic              last;
		logic [6:0]        count;
	} result_t;

	typedef struct {
		ille_pkg::op_t op;
		logic [31:0]   value;
		bit            typed;
		result_t       exp;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ille_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // value
	logic [ille_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;  // op
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [ille_pkg::M_TDATA_W-1:0] m_axis_tdata;       // item_value, count, zero pad
	logic [ille_pkg::M_TUSER_W-1:0] m_axis_tuser;       // status, item_valid
	logic m_axis_tlast;

	indexed_linked_list_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	// model of the node store
	logic [31:0] node_value [NODES];
	logic [6:0]  node_next  [NODES];
	logic [6:0]  list_head;
	logic [6:0]  free_head;
	logic [6:0]  list_len;

	result_t step_results [$];
	result_t expected_results [$];
	int      mismatches = 0;

	// request side sideband, travels with the request
	bit      req_typed = 1'b0;
	result_t req_exp = '0;

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	request_row_t directed_rows [24] = '{
		'{ille_pkg::OP_DUMP,    32'd0,         1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd0}},
		'{ille_pkg::OP_DELETE,  32'd5,         1'b1,
			'{ille_pkg::ST_EMPTY,     32'd0, 1'b0, 1'b1, 7'd0}},
		'{ille_pkg::OP_REVERSE, 32'd0,         1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd0}},
		'{ille_pkg::OP_APPEND,  32'h8000_0000, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd1}},
		'{ille_pkg::OP_APPEND,  32'h7fff_ffff, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd2}},
		'{ille_pkg::OP_APPEND,  32'd0,         1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd3}},
		'{ille_pkg::OP_APPEND,  32'hffff_ffff, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd4}},
		'{ille_pkg::OP_DUMP,    32'd0,         1'b0, '0},
		'{ille_pkg::OP_DELETE,  32'd12345,     1'b1,
			'{ille_pkg::ST_NOT_FOUND, 32'd0, 1'b0, 1'b1, 7'd4}},
		'{ille_pkg::OP_REVERSE, 32'd0,         1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd4}},
		'{ille_pkg::OP_DUMP,    32'hffff_ffff, 1'b0, '0},
		'{ille_pkg::OP_DELETE,  32'hffff_ffff, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd3}},
		'{ille_pkg::OP_DELETE,  32'h8000_0000, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd2}},
		'{ille_pkg::OP_APPEND,  32'h7fff_ffff, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd3}},
		'{ille_pkg::OP_APPEND,  32'h5555_5555, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd4}},
		'{ille_pkg::OP_APPEND,  32'haaaa_aaaa, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd5}},
		'{ille_pkg::OP_DELETE,  32'h7fff_ffff, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd4}},
		'{ille_pkg::OP_DUMP,    32'd0,         1'b0, '0},
		'{ille_pkg::OP_DELETE,  32'd0,         1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd3}},
		'{ille_pkg::OP_DELETE,  32'h7fff_ffff, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd2}},
		'{ille_pkg::OP_DELETE,  32'h5555_5555, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd1}},
		'{ille_pkg::OP_DELETE,  32'haaaa_aaaa, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd0}},
		'{ille_pkg::OP_DUMP,    32'h1234_5678, 1'b1,
			'{ille_pkg::ST_OK,        32'd0, 1'b0, 1'b1, 7'd0}},
		'{ille_pkg::OP_DELETE,  32'd1,         1'b1,
			'{ille_pkg::ST_EMPTY,     32'd0, 1'b0, 1'b1, 7'd0}}
	};

	function automatic result_t outcome(ille_pkg::status_t st, logic [31:0] v, logic valid,
		logic lst);
		return '{st, v, valid, lst, list_len};
	endfunction

	task automatic apply_command(input ille_pkg::op_t op, input logic [31:0] v);
		logic [6:0] cur;
		logic [6:0] prev;
		logic [6:0] nxt;
		int         k;
		step_results.delete();
		case (op)
			ille_pkg::OP_APPEND: begin
				cur = free_head;
				if (cur >= NODES) begin
					step_results.push_back(outcome(ille_pkg::ST_FULL, 32'd0, 1'b0, 1'b1));
				end else begin
					free_head = node_next[cur];
					node_value[cur] = v;
					node_next[cur] = ille_pkg::NULL_LINK;
					if (list_head >= NODES) begin
						list_head = cur;
					end else begin
						prev = list_head;
						for (k = 0; k < NODES && node_next[prev] < NODES; k++)
							prev = node_next[prev];
						node_next[prev] = cur;
					end
					if (list_len < NODES)
						list_len++;
					step_results.push_back(outcome(ille_pkg::ST_OK, 32'd0, 1'b0, 1'b1));
				end
			end
			ille_pkg::OP_DELETE: begin
				cur = list_head;
				prev = ille_pkg::NULL_LINK;
				if (cur >= NODES) begin
					step_results.push_back(outcome(ille_pkg::ST_EMPTY, 32'd0, 1'b0, 1'b1));
				end else begin
					for (k = 0; k < NODES && cur < NODES && node_value[cur] != v; k++) begin
						prev = cur;
						cur = node_next[cur];
					end
					if (cur >= NODES || node_value[cur] != v) begin
						step_results.push_back(outcome(ille_pkg::ST_NOT_FOUND, 32'd0, 1'b0,
							1'b1));
					end else begin
						if (prev < NODES)
							node_next[prev] = node_next[cur];
						else
							list_head = node_next[cur];
						node_next[cur] = free_head;
						free_head = cur;
						if (list_len > 0)
							list_len--;
						step_results.push_back(outcome(ille_pkg::ST_OK, 32'd0, 1'b0, 1'b1));
					end
				end
			end
			ille_pkg::OP_REVERSE: begin
				prev = ille_pkg::NULL_LINK;
				cur = list_head;
				for (k = 0; k < NODES && cur < NODES; k++) begin
					nxt = node_next[cur];
					node_next[cur] = prev;
					prev = cur;
					cur = nxt;
				end
				list_head = prev;
				step_results.push_back(outcome(ille_pkg::ST_OK, 32'd0, 1'b0, 1'b1));
			end
			default: begin
				cur = list_head;
				if (cur >= NODES) begin
					step_results.push_back(outcome(ille_pkg::ST_OK, 32'd0, 1'b0, 1'b1));
				end else begin
					k = 0;
					while (k < NODES && cur < NODES) begin
						nxt = node_next[cur];
						step_results.push_back(outcome(ille_pkg::ST_OK, node_value[cur], 1'b1,
							(k + 1 >= NODES || nxt >= NODES)));
						k++;
						cur = nxt;
					end
				end
			end
		endcase
	endtask

	// requests and results are both taken at the rising edge
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (s_axis_tvalid && s_axis_tready) begin
			apply_command(ille_pkg::op_t'(s_axis_tuser), s_axis_tdata);
			if (req_typed)
				expected_results.push_back(req_exp);
			else
				foreach (step_results[k])
					expected_results.push_back(step_results[k]);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{ille_pkg::status_t'(m_axis_tuser[1:0]), m_axis_tdata[31:0],
				m_axis_tuser[2], m_axis_tlast, m_axis_tdata[38:32]};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d value %0d valid %0b last %0b count %0d",
					$time, got.status, $signed(got.item_value), got.item_valid, got.last,
					got.count);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					$display("%0t: expected status %0d value %0d valid %0b last %0b count %0d",
						$time, want.status, $signed(want.item_value), want.item_valid,
						want.last, want.count);
					$display("%0t: actual   status %0d value %0d valid %0b last %0b count %0d",
						$time, got.status, $signed(got.item_value), got.item_valid,
						got.last, got.count);
					mismatches++;
				end
			end
		end
	end

	// result side: random stalls, one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= calm || ($urandom_range(99) >= 10);
		end
	end

	task automatic send_request(input ille_pkg::op_t op, input logic [31:0] v, input bit typed,
		input result_t exp);
		if (!calm && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tuser <= op;
		req_typed <= typed;
		req_exp <= exp;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		ille_pkg::op_t op;
		logic [31:0]   v;
		logic [6:0]    cur;
		int            r;
		int            steps;
		int            full_hits;
		int            empty_hits;
		bit            growing;
		for (int i = 0; i < NODES; i++) begin
			node_value[i] = '0;
			node_next[i] = (i == NODES - 1) ? ille_pkg::NULL_LINK : 7'(i + 1);
		end
		list_head = ille_pkg::NULL_LINK;
		free_head = '0;
		list_len = '0;
		full_hits = 0;
		empty_hits = 0;
		growing = 1'b1;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].exp);

		// grow until appends are refused, then drain until deletes find nothing
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 180 && i < 240);
			if (i == 100)
				hold_req <= 1'b1;
			r = $urandom_range(99);
			if (growing)
				op = (r < 70) ? ille_pkg::OP_APPEND : (r < 80) ? ille_pkg::OP_DELETE :
					(r < 90) ? ille_pkg::OP_REVERSE : ille_pkg::OP_DUMP;
			else
				op = (r < 12) ? ille_pkg::OP_APPEND : (r < 80) ? ille_pkg::OP_DELETE :
					(r < 90) ? ille_pkg::OP_REVERSE : ille_pkg::OP_DUMP;
			if (growing && op == ille_pkg::OP_APPEND && list_len == NODES) begin
				full_hits = full_hits + 1;
				if (full_hits >= 3) begin
					growing = 1'b0;
					full_hits = 0;
				end
			end
			if (!growing && op == ille_pkg::OP_DELETE && list_len == 0) begin
				empty_hits = empty_hits + 1;
				if (empty_hits >= 2) begin
					growing = 1'b1;
					empty_hits = 0;
				end
			end
			v = $urandom;
			if (op == ille_pkg::OP_APPEND) begin
				r = $urandom_range(9);
				if (r >= 8) begin
					case ($urandom_range(3))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = 32'hffff_ffff;
						default: v = 32'd0;
					endcase
				end else if (r >= 6) begin
					v = $urandom_range(3);
				end
			end else if (op == ille_pkg::OP_DELETE) begin
				if (list_len > 0 && $urandom_range(3) != 0) begin
					cur = list_head;
					steps = $urandom_range(list_len - 1);
					for (int k = 0; k < steps; k++)
						cur = node_next[cur];
					v = node_value[cur];
				end else if ($urandom_range(1) == 0) begin
					v = $urandom_range(3);
				end
			end
			send_request(op, v, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
